// ===== src/gfa_pkg.sv =====
// gfa_pkg: shared types and constants for the golay frame accumulator
// no dependencies; imported by gfa_bank_ram and golay_frame_accumulator_unit
`timescale 1ns / 1ps
`default_nettype none

package gfa_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BANKS       = 4;
  localparam int unsigned FP_W        = 13;
  localparam int unsigned FPS_W       = 16;
  localparam int unsigned PIDX_W      = 12;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned MAX_POINTS_DEF = 4096;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BANKS-1:0][WORD_W-1:0] bank_row_t;

  // bank order in golay mode
  typedef enum logic [1:0] {
    BANK_AP = 2'd0,
    BANK_AN = 2'd1,
    BANK_BP = 2'd2,
    BANK_BN = 2'd3
  } bank_t;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_ABORT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_POINTS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_STEP = 2'd2;

  localparam logic [FP_W-1:0]  FRAME_POINTS_RST    = 13'd4096;
  localparam logic [FPS_W-1:0] FRAMES_PER_STEP_RST = 16'd1;

  // lane write command from the update stage to the bank memory
  typedef struct packed {
    logic  en;
    bank_t lane;
    word_t data;
  } lane_wr_t;

endpackage

`default_nettype wire

// ===== src/golay_frame_accumulator_unit.sv =====
// golay_frame_accumulator_unit: top level of the coherent frame accumulator
// depends on gfa_pkg and gfa_bank_ram
`timescale 1ns / 1ps
`default_nettype none

// Accepts one word per clock: a trace sample or an abort. Each sample is
// accumulated at its point position into the bank in use (AP only in
// single-pulse mode, AP/AN/BP/BN in turn in Golay mode). The bank memory
// holds one row per point with one lane per bank. An accepted sample's row
// is read into a register; the update stage forms and writes back the sum
// and loads any result word into the output register. A write to the row
// being read in the same cycle is forwarded into the sum. In the final
// frame of bank BN (AP in single-pulse mode) each point gives one result
// word from the same row read: the AP sum, AP-AN and BP-BN. Sustained rate
// is one sample per cycle; the input stalls only while a waiting result is
// stalled at the output. No clearing: each bank's first frame overwrites.
module golay_frame_accumulator_unit #(
  parameter int unsigned MAX_POINTS = gfa_pkg::MAX_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // sample channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic signed [31:0]          in_sample,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gfa_pkg::PIDX_W-1:0]       out_point_index,
  output logic signed [31:0]               out_positive_a_sum,
  output logic signed [31:0]               out_a_difference,
  output logic signed [31:0]               out_b_difference,
  output logic                             out_last_point,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [gfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gfa_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W = ((POS_W > FP_W) ? POS_W : FP_W) + 1;

  // configuration
  logic              single_mode_r;
  logic [FP_W-1:0]   frame_points_r;
  logic [FPS_W-1:0]  frames_per_step_r;

  // sequencing
  bank_t             phase_r;
  logic [FPS_W-1:0]  frame_count_r;
  logic [POS_W-1:0]  point_pos_r;

  // update stage
  logic              s1_valid_r;
  logic [POS_W-1:0]  s1_pos_r;
  bank_t             s1_bank_r;
  logic              s1_first_r;
  logic              s1_emit_r;
  logic              s1_single_r;
  logic              s1_last_r;
  word_t             s1_sample_r;
  logic              s1_fwd_r;
  bank_t             fwd_lane_r;
  word_t             fwd_data_r;

  // output register
  logic              out_valid_r;
  logic [PIDX_W-1:0] out_idx_r;
  word_t             out_ap_r;
  word_t             out_da_r;
  word_t             out_db_r;
  logic              out_last_r;

  logic              accept;
  logic              fp_bad;
  logic              take_sample;
  bank_t             bank;
  logic [CMP_W-1:0]  fp_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic [POS_W-1:0]  pos;
  logic              last_in_frame;
  logic              final_frame;
  logic              s1_blocked;
  logic              s1_go;
  bank_row_t         rd_row;
  bank_row_t         row_fwd;
  word_t             acc;
  word_t             res_ap;
  word_t             res_da;
  word_t             res_db;
  lane_wr_t          wr_cmd;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_mode_r     <= 1'b0;
      frame_points_r    <= FRAME_POINTS_RST;
      frames_per_step_r <= FRAMES_PER_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SINGLE_MODE:     single_mode_r     <= cfg_data[0];
        CFG_FRAME_POINTS:    frame_points_r    <= cfg_data[FP_W-1:0];
        CFG_FRAMES_PER_STEP: frames_per_step_r <= cfg_data[FPS_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ accept stage
  assign s1_blocked = s1_emit_r && out_valid_r && out_stall;
  assign s1_go      = s1_valid_r && !s1_blocked;
  assign in_stall   = s1_valid_r && s1_blocked;
  assign accept     = in_valid && !in_stall;

  assign fp_ext  = CMP_W'(frame_points_r);
  assign fp_bad  = (frame_points_r == '0) || (fp_ext > CMP_W'(MAX_POINTS));
  assign take_sample = accept && (in_func == FUNC_SAMPLE) && !fp_bad;

  assign bank    = single_mode_r ? BANK_AP : phase_r;
  // a lowered frame length clamps the position to the last point
  assign pos_ext = (CMP_W'(point_pos_r) >= fp_ext) ? (fp_ext - CMP_W'(1))
                                                   : CMP_W'(point_pos_r);
  assign pos     = pos_ext[POS_W-1:0];
  assign last_in_frame = (pos_ext + CMP_W'(1)) >= fp_ext;
  assign final_frame   = ({1'b0, frame_count_r} + 17'd1) >= {1'b0, frames_per_step_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= BANK_AP;
      frame_count_r <= '0;
      point_pos_r   <= '0;
    end else if (accept) begin
      if (!take_sample) begin
        phase_r       <= BANK_AP;
        frame_count_r <= '0;
        point_pos_r   <= '0;
      end else if (!last_in_frame) begin
        point_pos_r <= pos + POS_W'(1);
      end else begin
        point_pos_r <= '0;
        if (!final_frame) begin
          frame_count_r <= frame_count_r + FPS_W'(1);
        end else begin
          frame_count_r <= '0;
          if (!single_mode_r) begin
            phase_r <= bank_t'(bank + 2'd1);
          end
        end
      end
    end
  end

  // ----------------------------------------------------------- update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take_sample) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      s1_pos_r    <= pos;
      s1_bank_r   <= bank;
      s1_first_r  <= (frame_count_r == '0);
      s1_emit_r   <= final_frame && (single_mode_r || bank == BANK_BN);
      s1_single_r <= single_mode_r;
      s1_last_r   <= last_in_frame;
      s1_sample_r <= word_t'(in_sample);
      // the row read now misses the write that the update stage does now
      s1_fwd_r    <= s1_valid_r && (s1_pos_r == pos);
    end
    if (wr_cmd.en) begin
      fwd_lane_r <= wr_cmd.lane;
      fwd_data_r <= wr_cmd.data;
    end
  end

  always_comb begin
    row_fwd = rd_row;
    if (s1_fwd_r) begin
      row_fwd[fwd_lane_r] = fwd_data_r;
    end
    acc = s1_first_r ? s1_sample_r : (row_fwd[s1_bank_r] + s1_sample_r);
    if (s1_single_r) begin
      res_ap = acc;
      res_da = '0;
      res_db = '0;
    end else begin
      res_ap = row_fwd[BANK_AP];
      res_da = row_fwd[BANK_AP] - row_fwd[BANK_AN];
      res_db = row_fwd[BANK_BP] - acc;
    end
    wr_cmd.en   = s1_go;
    wr_cmd.lane = s1_bank_r;
    wr_cmd.data = acc;
  end

  gfa_bank_ram #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (POS_W)
  ) u_bank_ram (
    .clk     (clk),
    .rd_en   (take_sample),
    .rd_addr (pos),
    .rd_row  (rd_row),
    .wr_addr (s1_pos_r),
    .wr      (wr_cmd)
  );

  // --------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_idx_r  <= PIDX_W'(s1_pos_r);
      out_ap_r   <= res_ap;
      out_da_r   <= res_da;
      out_db_r   <= res_db;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_point_index    = out_idx_r;
  assign out_positive_a_sum = out_ap_r;
  assign out_a_difference   = out_da_r;
  assign out_b_difference   = out_db_r;
  assign out_last_point     = out_last_r;

  // -------------------------------------------------------------- assertions
  a_stall_only_on_full_output: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_emit_r)
  ) else $error("input stalled without a waiting result");

  a_fwd_follows_write: assert property (
    @(posedge clk) disable iff (!rst_n)
    take_sample |=> (!s1_fwd_r || $past(wr_cmd.en))
  ) else $error("forward flagged without a same-cycle write");

  a_emit_bank: assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_emit_r) |-> (s1_single_r || s1_bank_r == BANK_BN)
  ) else $error("result raised outside the final bank");

  a_result_loaded_by_update: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_emit_r)
  ) else $error("result word appeared without an update");

endmodule

`default_nettype wire

// ===== src/gfa_bank_ram.sv =====
// gfa_bank_ram: frame accumulator store, one row per point, one lane per bank
// depends on gfa_pkg; registered read of a whole row, single-lane write
`timescale 1ns / 1ps
`default_nettype none

module gfa_bank_ram #(
  parameter int unsigned DEPTH  = gfa_pkg::MAX_POINTS_DEF,
  parameter int unsigned ADDR_W = $clog2(gfa_pkg::MAX_POINTS_DEF)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output gfa_pkg::bank_row_t     rd_row,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire gfa_pkg::lane_wr_t wr
);
  import gfa_pkg::*;

  bank_row_t mem_q [DEPTH];
  bank_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_q[wr_addr][wr.lane] <= wr.data;
    end
    // read-before-write; the caller forwards a same-cycle write
    if (rd_en) begin
      rd_row_r <= mem_q[rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

`default_nettype wire
